/* design/kda_pkg.sv */
// ----------------------------------------------------------------------------
// kda_pkg
// Shared types, constants and table lookup for the key debounce and
// autorepeat block.
// ----------------------------------------------------------------------------
package kda_pkg;

    // key and field widths
    localparam int KEY_COUNT  = 3;
    localparam int KEY_W      = 3;
    localparam int HOLD_W     = 32;
    localparam int PRESS_W    = 8;
    localparam int IDX_W      = 4;
    localparam int ENTRY_W    = 8;
    localparam int CFG_W      = 64;
    localparam int TBL_W      = 2 * CFG_W;

    localparam logic [KEY_W-1:0]   KEY_MASK  = KEY_W'((64'd1 << KEY_COUNT) - 64'd1);
    localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

    // default repeat table 3,100,50,50,10,10,10,10,10,3,0,...
    localparam logic [CFG_W-1:0] RPT_LO_RST = 64'h0A0A_0A0A_3232_6403;
    localparam logic [CFG_W-1:0] RPT_HI_RST = 64'h0000_0000_0000_030A;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_RPT_LO = 1'b0,
        CFG_RPT_HI = 1'b1
    } cfg_idx_t;

    // request codes
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_TAKE  = 2'd1,
        REQ_LOCK  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key_sample;
        logic             clear_lock;
    } item_t;

    typedef struct packed {
        logic [KEY_W-1:0]   held_keys;
        logic [HOLD_W-1:0]  hold_ticks;
        logic [PRESS_W-1:0] pending_presses;
        logic [KEY_W-1:0]   taken_keys;
        logic               is_locked;
    } result_t;

    // entry of the 16-entry repeat table; index 16 reads as end of table
    function automatic logic [ENTRY_W-1:0] rpt_entry(
        input logic [TBL_W-1:0] rpt_tbl,
        input logic [IDX_W:0]   idx
    );
        logic [ENTRY_W-1:0] val;
        begin
            if (idx[IDX_W])
            begin
                val = '0;
            end
            else
            begin
                val = rpt_tbl[idx[IDX_W-1:0] * ENTRY_W +: ENTRY_W];
            end
            return val;
        end
    endfunction

endpackage

/* design/key_debounce_autorepeat_top.sv */
// ----------------------------------------------------------------------------
// key_debounce_autorepeat_top
// Keypad qualifier with debounce by stability and table-driven autorepeat.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in channel (valid/ready); each transfer carries a
//   request type, a raw key sample and a clear-lock flag. Every request gives
//   exactly one result on the out channel (valid/ready) holding the state
//   after that request and, for a take, the keys taken.
//   The request is captured in an input register, evaluated in one pass of
//   logic against the qualifier state and written to an output register;
//   output valid rises once the result is in the output register, and one
//   request is accepted every cycle while the output is taken.
//   When the receiver stalls, the output register holds its result and the
//   input register holds the next request; in_ready drops once both are
//   full and rises again on the cycle the result is taken.
//   The repeat table is written through cfg_we/cfg_index/cfg_data while no
//   request is in flight.
//   Reset clears all qualifier state and empties both registers; the repeat
//   table returns to its default 3,100,50,50,10,10,10,10,10,3.
// ----------------------------------------------------------------------------
module key_debounce_autorepeat_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     req_type,
    input  logic [kda_pkg::KEY_W-1:0]      key_sample,
    input  logic                           clear_lock,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [kda_pkg::KEY_W-1:0]      held_keys,
    output logic [kda_pkg::HOLD_W-1:0]     hold_ticks,
    output logic [kda_pkg::PRESS_W-1:0]    pending_presses,
    output logic [kda_pkg::KEY_W-1:0]      taken_keys,
    output logic                           is_locked,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [kda_pkg::CFG_W-1:0]      cfg_data
);

    logic                       in_valid_reg;
    kda_pkg::item_t             item_reg;
    logic                       out_valid_reg;
    kda_pkg::result_t           result_reg;
    kda_pkg::result_t           result_next;
    logic [kda_pkg::TBL_W-1:0]  rpt_tbl;
    logic                       advance;

    // repeat table
    kda_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rpt_tbl   (rpt_tbl)
    );

    // flow control between input and output registers
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.req_type   <= req_type;
            item_reg.key_sample <= key_sample;
            item_reg.clear_lock <= clear_lock;
        end
    end

    // qualifier state and next-state logic
    kda_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .item    (item_reg),
        .rpt_tbl (rpt_tbl),
        .result  (result_next)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign held_keys       = result_reg.held_keys;
    assign hold_ticks      = result_reg.hold_ticks;
    assign pending_presses = result_reg.pending_presses;
    assign taken_keys      = result_reg.taken_keys;
    assign is_locked       = result_reg.is_locked;

endmodule

/* design/kda_cfg_regs.sv */
// ----------------------------------------------------------------------------
// kda_cfg_regs
// Repeat interval table registers, written through the configuration port.
// ----------------------------------------------------------------------------
module kda_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [kda_pkg::CFG_W-1:0]   cfg_data,
    output logic [kda_pkg::TBL_W-1:0]   rpt_tbl
);

    logic [kda_pkg::CFG_W-1:0] rpt_lo_reg;
    logic [kda_pkg::CFG_W-1:0] rpt_hi_reg;

    // register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpt_lo_reg <= kda_pkg::RPT_LO_RST;
            rpt_hi_reg <= kda_pkg::RPT_HI_RST;
        end
        else if (cfg_we)
        begin
            unique case (kda_pkg::cfg_idx_t'(cfg_index))
                kda_pkg::CFG_RPT_LO: rpt_lo_reg <= cfg_data;
                kda_pkg::CFG_RPT_HI: rpt_hi_reg <= cfg_data;
                default:             rpt_lo_reg <= rpt_lo_reg;
            endcase
        end
    end

    assign rpt_tbl = {rpt_hi_reg, rpt_lo_reg};

endmodule

/* design/kda_core.sv */
// ----------------------------------------------------------------------------
// kda_core
// Qualifier state and the single-pass next-state logic for one request.
// ----------------------------------------------------------------------------
module kda_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  kda_pkg::item_t             item,
    input  logic [kda_pkg::TBL_W-1:0]  rpt_tbl,
    output kda_pkg::result_t           result
);

    logic [kda_pkg::KEY_W-1:0]   prev_sample_reg, prev_sample_next;
    logic [kda_pkg::KEY_W-1:0]   stable_keys_reg, stable_keys_next;
    logic [kda_pkg::HOLD_W-1:0]  hold_counter_reg, hold_counter_next;
    logic [kda_pkg::PRESS_W-1:0] press_count_reg, press_count_next;
    logic [kda_pkg::HOLD_W-1:0]  next_repeat_reg, next_repeat_next;
    logic [kda_pkg::IDX_W-1:0]   interval_idx_reg, interval_idx_next;
    logic                        lock_flag_reg, lock_flag_next;

    logic [kda_pkg::KEY_W-1:0]   sample;
    logic [kda_pkg::KEY_W-1:0]   taken;
    logic [kda_pkg::IDX_W:0]     idx_up;
    logic [kda_pkg::ENTRY_W-1:0] entry_up;
    logic [kda_pkg::ENTRY_W-1:0] entry_cur;
    logic [kda_pkg::ENTRY_W-1:0] entry_first;
    logic [kda_pkg::HOLD_W-1:0]  hold_inc;

    // table lookups
    assign sample      = item.key_sample & kda_pkg::KEY_MASK;
    assign idx_up      = {1'b0, interval_idx_reg} + (kda_pkg::IDX_W+1)'(1);
    assign entry_up    = kda_pkg::rpt_entry(rpt_tbl, idx_up);
    assign entry_cur   = kda_pkg::rpt_entry(rpt_tbl, {1'b0, interval_idx_reg});
    assign entry_first = kda_pkg::rpt_entry(rpt_tbl, '0);
    assign hold_inc    = hold_counter_reg + kda_pkg::HOLD_W'(1);

    // next state for one request
    always_comb
    begin
        prev_sample_next  = prev_sample_reg;
        stable_keys_next  = stable_keys_reg;
        hold_counter_next = hold_counter_reg;
        press_count_next  = press_count_reg;
        next_repeat_next  = next_repeat_reg;
        interval_idx_next = interval_idx_reg;
        lock_flag_next    = lock_flag_reg;
        taken             = '0;
        unique case (kda_pkg::req_kind_t'(item.req_type))
            kda_pkg::REQ_TICK:
            begin
                if (sample != prev_sample_reg)
                begin
                    // sample changed: start over
                    prev_sample_next  = sample;
                    stable_keys_next  = '0;
                    hold_counter_next = '0;
                    press_count_next  = '0;
                    interval_idx_next = '0;
                    next_repeat_next  = kda_pkg::HOLD_W'(entry_first);
                end
                else if (sample == '0 || lock_flag_reg)
                begin
                    if (sample == '0)
                    begin
                        lock_flag_next = 1'b0;
                    end
                end
                else
                begin
                    hold_counter_next = hold_inc;
                    stable_keys_next  = sample;
                    if (hold_inc >= next_repeat_reg)
                    begin
                        if (press_count_reg != kda_pkg::PRESS_MAX)
                        begin
                            press_count_next = press_count_reg + kda_pkg::PRESS_W'(1);
                        end
                        // advance through the table, last non-zero entry repeats
                        if (entry_up != '0)
                        begin
                            interval_idx_next = idx_up[kda_pkg::IDX_W-1:0];
                            next_repeat_next  = next_repeat_reg
                                              + kda_pkg::HOLD_W'(entry_up);
                        end
                        else
                        begin
                            next_repeat_next  = next_repeat_reg
                                              + kda_pkg::HOLD_W'(entry_cur);
                        end
                    end
                end
            end
            kda_pkg::REQ_TAKE:
            begin
                if (press_count_reg != '0)
                begin
                    press_count_next = press_count_reg - kda_pkg::PRESS_W'(1);
                    taken            = stable_keys_reg;
                end
            end
            kda_pkg::REQ_LOCK:
            begin
                lock_flag_next = 1'b1;
            end
            kda_pkg::REQ_CLEAR:
            begin
                prev_sample_next  = sample;
                stable_keys_next  = '0;
                hold_counter_next = '0;
                press_count_next  = '0;
                interval_idx_next = '0;
                next_repeat_next  = kda_pkg::HOLD_W'(entry_first);
                if (item.clear_lock)
                begin
                    lock_flag_next = 1'b1;
                end
            end
            default:
            begin
                lock_flag_next = lock_flag_reg;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg  <= '0;
            stable_keys_reg  <= '0;
            hold_counter_reg <= '0;
            press_count_reg  <= '0;
            next_repeat_reg  <= '0;
            interval_idx_reg <= '0;
            lock_flag_reg    <= 1'b0;
        end
        else if (step)
        begin
            prev_sample_reg  <= prev_sample_next;
            stable_keys_reg  <= stable_keys_next;
            hold_counter_reg <= hold_counter_next;
            press_count_reg  <= press_count_next;
            next_repeat_reg  <= next_repeat_next;
            interval_idx_reg <= interval_idx_next;
            lock_flag_reg    <= lock_flag_next;
        end
    end

    // result reflects the state after this request
    assign result.held_keys       = stable_keys_next;
    assign result.hold_ticks      = hold_counter_next;
    assign result.pending_presses = press_count_next;
    assign result.taken_keys      = taken;
    assign result.is_locked       = lock_flag_next;

`ifndef SYNTHESIS
    a_lock_sets: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.req_type == kda_pkg::REQ_LOCK |=> lock_flag_reg)
        else $error("lock request did not set the lock");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.req_type == kda_pkg::REQ_CLEAR |=>
            press_count_reg == '0 && hold_counter_reg == '0 && stable_keys_reg == '0)
        else $error("clear left qualifier state behind");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(press_count_reg) && $stable(hold_counter_reg)
                  && $stable(lock_flag_reg))
        else $error("state changed without a transfer");
`endif

endmodule

/* test/tb_key_debounce_autorepeat_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_debounce_autorepeat_top
// Self-checking bench for the keypad debounce and autorepeat block. A small
// scoreboard class keeps its own copy of the qualifier state and repeat
// table, predicts the result of every request transfer and compares each
// result transfer field by field. The run steps through several repeat
// tables and idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_key_debounce_autorepeat_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_STALL  = 60;
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES  = 6;
    localparam int SAT_HOLD    = 270;

    // scoreboard: qualifier prediction and queue of expected results
    class press_scoreboard;
        logic [kda_pkg::TBL_W-1:0]   rpt_bits;
        logic [kda_pkg::KEY_W-1:0]   last_sample;
        logic [kda_pkg::KEY_W-1:0]   stable;
        logic [kda_pkg::HOLD_W-1:0]  hold_cnt;
        logic [kda_pkg::HOLD_W-1:0]  next_at;
        logic [kda_pkg::PRESS_W-1:0] presses;
        logic [kda_pkg::IDX_W-1:0]   step_idx;
        logic                        locked;
        kda_pkg::result_t            expected_q[$];
        int                          errors;
        int                          checked;
        int                          keys_taken;
        int                          saturated;
        int                          table_end;

        function new();
            rpt_bits    = {kda_pkg::RPT_HI_RST, kda_pkg::RPT_LO_RST};
            last_sample = '0;
            stable      = '0;
            hold_cnt    = '0;
            next_at     = '0;
            presses     = '0;
            step_idx    = '0;
            locked      = 1'b0;
            errors      = 0;
            checked     = 0;
            keys_taken  = 0;
            saturated   = 0;
            table_end   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // entries past the sixteenth read as end of table
        function logic [kda_pkg::ENTRY_W-1:0] interval_at(int unsigned i);
            if (i >= 16)
            begin
                return '0;
            end
            return rpt_bits[i*kda_pkg::ENTRY_W +: kda_pkg::ENTRY_W];
        endfunction

        function void restart(logic [kda_pkg::KEY_W-1:0] s, logic lock_in);
            last_sample = s;
            stable      = '0;
            hold_cnt    = '0;
            presses     = '0;
            step_idx    = '0;
            next_at     = kda_pkg::HOLD_W'(interval_at(0));
            if (lock_in)
            begin
                locked = 1'b1;
            end
        endfunction

        function void tick(logic [kda_pkg::KEY_W-1:0] s);
            if (s != last_sample)
            begin
                restart(s, 1'b0);
            end
            else if (s == '0 || locked)
            begin
                // release of all keys lifts the lock
                if (s == '0)
                begin
                    locked = 1'b0;
                end
            end
            else
            begin
                hold_cnt = hold_cnt + 1'b1;
                stable   = s;
                if (hold_cnt >= next_at)
                begin
                    if (presses != kda_pkg::PRESS_MAX)
                    begin
                        presses = presses + 1'b1;
                    end
                    else
                    begin
                        saturated++;
                    end
                    if (step_idx == '1)
                    begin
                        table_end++;
                    end
                    if (interval_at(int'(step_idx) + 1) != '0)
                    begin
                        step_idx = step_idx + 1'b1;
                    end
                    next_at = next_at + kda_pkg::HOLD_W'(interval_at(step_idx));
                end
            end
        endfunction

        function void note_request(kda_pkg::req_kind_t kind,
                                   logic [kda_pkg::KEY_W-1:0] sample_in,
                                   logic lock_in);
            logic [kda_pkg::KEY_W-1:0] s;
            logic [kda_pkg::KEY_W-1:0] taken;
            kda_pkg::result_t          r;
            s     = sample_in & kda_pkg::KEY_MASK;
            taken = '0;
            case (kind)
                kda_pkg::REQ_TICK: tick(s);
                kda_pkg::REQ_TAKE:
                begin
                    if (presses != '0)
                    begin
                        presses = presses - 1'b1;
                        taken   = stable;
                        keys_taken++;
                    end
                end
                kda_pkg::REQ_LOCK: locked = 1'b1;
                default:           restart(s, lock_in);
            endcase
            r.held_keys       = stable;
            r.hold_ticks      = hold_cnt;
            r.pending_presses = presses;
            r.taken_keys      = taken;
            r.is_locked       = locked;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [kda_pkg::HOLD_W-1:0] want,
                                    logic [kda_pkg::HOLD_W-1:0] seen);
            if (want !== seen)
            begin
                $display("%0t: %s differs, expected %0h actual %0h", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(kda_pkg::result_t got);
            kda_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with no request outstanding, expected none actual %p",
                         $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("held_keys", kda_pkg::HOLD_W'(want.held_keys),
                          kda_pkg::HOLD_W'(got.held_keys));
            compare_field("hold_ticks", want.hold_ticks, got.hold_ticks);
            compare_field("pending_presses", kda_pkg::HOLD_W'(want.pending_presses),
                          kda_pkg::HOLD_W'(got.pending_presses));
            compare_field("taken_keys", kda_pkg::HOLD_W'(want.taken_keys),
                          kda_pkg::HOLD_W'(got.taken_keys));
            compare_field("is_locked", kda_pkg::HOLD_W'(want.is_locked),
                          kda_pkg::HOLD_W'(got.is_locked));
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [1:0]                   req_type;
    logic [kda_pkg::KEY_W-1:0]    key_sample;
    logic                         clear_lock;
    logic                         out_valid;
    logic                         out_ready;
    logic [kda_pkg::KEY_W-1:0]    held_keys;
    logic [kda_pkg::HOLD_W-1:0]   hold_ticks;
    logic [kda_pkg::PRESS_W-1:0]  pending_presses;
    logic [kda_pkg::KEY_W-1:0]    taken_keys;
    logic                         is_locked;
    logic                         cfg_we;
    logic                         cfg_index;
    logic [kda_pkg::CFG_W-1:0]    cfg_data;

    press_scoreboard     sb = new();
    kda_pkg::result_t    seen_result;
    int                  items_sent = 0;
    int                  tx_idle_pct = 0;
    int                  rx_idle_pct = 0;
    int                  stall_requests = 0;
    int                  stall_served = 0;
    int                  stall_left = 0;
    int                  cycle_count = 0;
    int                  tables_loaded = 0;

    key_debounce_autorepeat_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .key_sample      (key_sample),
        .clear_lock      (clear_lock),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .held_keys       (held_keys),
        .hold_ticks      (hold_ticks),
        .pending_presses (pending_presses),
        .taken_keys      (taken_keys),
        .is_locked       (is_locked),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // monitor: check the result transfer first, then note the request transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen_result = {held_keys, hold_ticks, pending_presses, taken_keys, is_locked};
                sb.check_result(seen_result);
            end
            if (in_valid && in_ready)
            begin
                sb.note_request(kda_pkg::req_kind_t'(req_type), key_sample, clear_lock);
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (stall_served != stall_requests)
            begin
                stall_served++;
                stall_left = LONG_STALL;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // offer one request and wait for its transfer; valid stays up afterwards
    task automatic send_request(kda_pkg::req_kind_t kind,
                                logic [kda_pkg::KEY_W-1:0] sample_in,
                                logic lock_in);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        key_sample <= sample_in;
        clear_lock <= lock_in;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // hold one sample for a number of ticks, with takes mixed in
    task automatic hold_run(logic [kda_pkg::KEY_W-1:0] s, int ticks, int take_pct);
        repeat (ticks)
        begin
            send_request(kda_pkg::REQ_TICK, s, 1'($urandom));
            if ($urandom_range(99) < take_pct)
            begin
                send_request(kda_pkg::REQ_TAKE, kda_pkg::KEY_W'($urandom), 1'($urandom));
            end
        end
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        @(posedge clk);
    endtask

    // write both table registers on consecutive edges
    task automatic load_table(logic [kda_pkg::TBL_W-1:0] rpt);
        cfg_we    <= 1'b1;
        cfg_index <= kda_pkg::CFG_RPT_LO;
        cfg_data  <= rpt[kda_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_index <= kda_pkg::CFG_RPT_HI;
        cfg_data  <= rpt[kda_pkg::TBL_W-1:kda_pkg::CFG_W];
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.rpt_bits = rpt;
        tables_loaded++;
    endtask

    // one random sequence, mostly a press, hold and release
    task automatic run_sequence();
        int                        pick;
        int                        n;
        logic [kda_pkg::KEY_W-1:0] s;
        pick = $urandom_range(99);
        s    = kda_pkg::KEY_W'($urandom_range(7, 1));
        if (pick < 65)
        begin
            hold_run(s, $urandom_range(24, 1), 25);
            n = $urandom_range(3);
            repeat (n) send_request(kda_pkg::REQ_TAKE, kda_pkg::KEY_W'($urandom),
                                    1'($urandom));
            hold_run('0, $urandom_range(2, 1), 0);
        end
        else if (pick < 75)
        begin
            send_request(kda_pkg::REQ_LOCK, kda_pkg::KEY_W'($urandom), 1'($urandom));
            hold_run(s, $urandom_range(4, 1), 20);
            hold_run('0, $urandom_range(2, 1), 0);
        end
        else if (pick < 85)
        begin
            s = kda_pkg::KEY_W'($urandom_range(7));
            send_request(kda_pkg::REQ_CLEAR, s, 1'($urandom));
            hold_run(s, $urandom_range(6, 1), 20);
        end
        else
        begin
            n = $urandom_range(4, 1);
            repeat (n)
            begin
                send_request(kda_pkg::req_kind_t'($urandom_range(3)),
                             kda_pkg::KEY_W'($urandom), 1'($urandom));
            end
        end
    endtask

    // stimulus
    initial
    begin
        int                        phase;
        int                        phase_start;
        int                        i;
        bit                        paused;
        logic [kda_pkg::TBL_W-1:0] rpt;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = kda_pkg::REQ_TICK;
        key_sample = '0;
        clear_lock = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = kda_pkg::CFG_RPT_LO;
        cfg_data   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset table, take with nothing pending, lock, clear
        send_request(kda_pkg::REQ_TAKE, '0, 1'b0);
        send_request(kda_pkg::REQ_TICK, 3'b111, 1'b1);
        hold_run(3'b111, 3, 0);
        send_request(kda_pkg::REQ_TAKE, '0, 1'b1);
        send_request(kda_pkg::REQ_TAKE, 3'b111, 1'b0);
        send_request(kda_pkg::REQ_LOCK, 3'b111, 1'b1);
        send_request(kda_pkg::REQ_TICK, 3'b111, 1'b0);
        send_request(kda_pkg::REQ_TICK, '0, 1'b0);
        send_request(kda_pkg::REQ_TICK, '0, 1'b1);
        send_request(kda_pkg::REQ_CLEAR, 3'b101, 1'b1);
        send_request(kda_pkg::REQ_TICK, 3'b101, 1'b0);
        send_request(kda_pkg::REQ_TICK, '0, 1'b0);
        send_request(kda_pkg::REQ_TICK, '0, 1'b0);
        send_request(kda_pkg::REQ_CLEAR, '0, 1'b0);
        hold_run(3'b010, 4, 0);
        send_request(kda_pkg::REQ_TICK, 3'b001, 1'b0);
        send_request(kda_pkg::REQ_LOCK, '0, 1'b0);
        send_request(kda_pkg::REQ_CLEAR, 3'b111, 1'b0);
        send_request(kda_pkg::REQ_TAKE, 3'b111, 1'b1);

        // random phases, each with its own table and idling pattern
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            case (phase)
                0, 4:
                begin
                    for (i = 0; i < 16; i++)
                    begin
                        rpt[i*kda_pkg::ENTRY_W +: kda_pkg::ENTRY_W] =
                            kda_pkg::ENTRY_W'($urandom_range(3, phase == 4));
                    end
                    // zero first entry in the later table; in both, an early end unless the index drawn is 16
                    if (phase == 4)
                    begin
                        rpt[kda_pkg::ENTRY_W-1:0] = '0;
                    end
                    i = $urandom_range(16, 2);
                    if (i < 16)
                    begin
                        rpt[i*kda_pkg::ENTRY_W +: kda_pkg::ENTRY_W] = '0;
                    end
                end
                1:       rpt = '0;
                2:       rpt = {16{8'h01}};
                3:       rpt = '1;
                default: rpt = {kda_pkg::RPT_HI_RST, kda_pkg::RPT_LO_RST};
            endcase
            load_table(rpt);
            tx_idle_pct = (phase < 2) ? 24 : (phase < 4) ? 83 : 0;
            rx_idle_pct = (phase < 2) ? 83 : (phase < 4) ? 24 : 0;
            if (phase == 1 || phase == 4)
            begin
                stall_requests = stall_requests + 1;
            end
            phase_start = items_sent;
            paused      = 1'b0;
            // every held tick presses, so a long hold saturates the count
            if (phase == 1)
            begin
                send_request(kda_pkg::REQ_CLEAR, '0, 1'b0);
                hold_run(3'b110, SAT_HOLD, 0);
            end
            // table with every entry one: index climbs to the last entry and stays
            if (phase == 2)
            begin
                hold_run(3'b011, 40, 10);
            end
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                run_sequence();
                if (phase == 2 && !paused && items_sent - phase_start > PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("covered %0d requests over %0d repeat tables, %0d results checked",
                 items_sent, tables_loaded, sb.checked);
        $display("takes with keys %0d, presses at saturation %0d, repeats at table end %0d",
                 sb.keys_taken, sb.saturated, sb.table_end);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
design/kda_pkg.sv
design/kda_cfg_regs.sv
design/kda_core.sv
design/key_debounce_autorepeat_top.sv
test/tb_key_debounce_autorepeat_top.sv
